// ----- rtl/srt_pkg.sv -----
// Shared types and codes for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [3:0]  slot;
      logic [15:0] service_time;
   } req_type;

   typedef struct packed {
      logic [15:0] current_time;
      logic        cpu_idle;
      logic [3:0]  running_slot;
      logic        finished;
      logic [15:0] turnaround;
      logic [15:0] waiting;
      logic [15:0] response;
      logic [15:0] idle_ticks;
   } rsp_type;

   // Per-cell strobes from the sequencer
   typedef struct packed {
      logic load;    // arrival targets this slot
      logic apply;   // tick commit cycle
      logic picked;  // this slot receives the tick
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/srt_cell.sv -----
// One task slot of the scheduler chain: slot state plus one stage of the min-search.
`timescale 1ns / 1ps
`default_nettype none

module srt_cell #(
   parameter int TIME_BITS = 16,
   parameter int IDX_W     = 4,
   parameter int IDX       = 0
) (
   input  wire                         clock,
   input  wire                         reset,
   input  srt_pkg::cell_ctrl_type      ctrl,
   input  wire  [TIME_BITS-1:0]        load_work,
   input  wire  [TIME_BITS-1:0]        now,
   // token from the previous cell
   input  wire                         tk_found_in,
   input  wire  [TIME_BITS-1:0]        tk_rem_in,
   input  wire  [IDX_W-1:0]            tk_idx_in,
   input  wire  [TIME_BITS-1:0]        tk_arr_in,
   input  wire  [TIME_BITS-1:0]        tk_wait_in,
   input  wire  [TIME_BITS-1:0]        tk_fr_in,
   input  wire                         tk_ran_in,
   // token to the next cell
   output logic                        tk_found_out,
   output logic [TIME_BITS-1:0]        tk_rem_out,
   output logic [IDX_W-1:0]            tk_idx_out,
   output logic [TIME_BITS-1:0]        tk_arr_out,
   output logic [TIME_BITS-1:0]        tk_wait_out,
   output logic [TIME_BITS-1:0]        tk_fr_out,
   output logic                        tk_ran_out
);

   localparam logic [TIME_BITS-1:0] TMAX = '1;

   logic                 ready_ff;
   logic                 ran_ff;
   logic [TIME_BITS-1:0] rem_ff;
   logic [TIME_BITS-1:0] arr_ff;
   logic [TIME_BITS-1:0] wait_ff;
   logic [TIME_BITS-1:0] fr_ff;
   logic                 take;

   // strict less-than keeps ties on the lower slot
   assign take = ready_ff && (!tk_found_in || (rem_ff < tk_rem_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         ran_ff   <= 1'b0;
      end else if (ctrl.load && !ready_ff) begin
         ready_ff <= 1'b1;
         ran_ff   <= 1'b0;
      end else if (ctrl.apply && ready_ff && ctrl.picked) begin
         ran_ff <= 1'b1;
         if (rem_ff <= TIME_BITS'(1)) begin
            ready_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load && !ready_ff) begin
         rem_ff  <= load_work;
         arr_ff  <= now;
         wait_ff <= '0;
      end else if (ctrl.apply && ready_ff) begin
         if (ctrl.picked) begin
            if (!ran_ff) begin
               fr_ff <= now;
            end
            if (rem_ff != '0) begin
               rem_ff <= rem_ff - TIME_BITS'(1);
            end
         end else if (wait_ff != TMAX) begin
            wait_ff <= wait_ff + TIME_BITS'(1);
         end
      end
   end

   // token valid flag is cleared by reset so the chain never carries an unknown valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         tk_found_out <= 1'b0;
      end else begin
         tk_found_out <= take || tk_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tk_rem_out   <= rem_ff;
         tk_idx_out   <= IDX_W'(IDX);
         tk_arr_out   <= arr_ff;
         tk_wait_out  <= wait_ff;
         tk_fr_out    <= fr_ff;
         tk_ran_out   <= ran_ff;
      end else begin
         tk_rem_out   <= tk_rem_in;
         tk_idx_out   <= tk_idx_in;
         tk_arr_out   <= tk_arr_in;
         tk_wait_out  <= tk_wait_in;
         tk_fr_out    <= tk_fr_in;
         tk_ran_out   <= tk_ran_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/srt_preemptive_scheduler.sv -----
// Top level of the preemptive shortest-remaining-time scheduler.
//
//  Channel | Ports                          | Direction | Carries
//  --------+--------------------------------+-----------+-------------------------------
//  req     | req_valid, req_ready, req_data | in        | arrival or tick transaction
//  rsp     | rsp_valid, rsp_ready, rsp_data | out       | one result per tick, none per arrival
//
// An arrival completes in its accept cycle. A tick passes through the accept cycle,
// the scan state while the search token flushes through the slot cells, and the
// commit state that updates every cell and loads the result register. Reset
// (synchronous, active high) empties every slot and clears the time, idle and scan
// counters. A stalled rsp holds the commit state; arrivals are still taken while a
// result waits in the idle state, and the next tick once its predecessor has committed.
`timescale 1ns / 1ps
`default_nettype none

module srt_preemptive_scheduler #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output srt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [TIME_BITS-1:0] idle_ff;
   logic                 rsp_valid_ff;
   srt_pkg::rsp_type     rsp_ff;

   // search token, index 0 is the empty seed
   logic                 tk_found [0:SLOTS];
   logic [TIME_BITS-1:0] tk_rem   [0:SLOTS];
   logic [IDX_W-1:0]     tk_idx   [0:SLOTS];
   logic [TIME_BITS-1:0] tk_arr   [0:SLOTS];
   logic [TIME_BITS-1:0] tk_wait  [0:SLOTS];
   logic [TIME_BITS-1:0] tk_fr    [0:SLOTS];
   logic                 tk_ran   [0:SLOTS];

   logic                 req_go;
   logic                 load_go;
   logic                 apply_go;
   logic [TIME_BITS-1:0] load_work;
   logic [SLOTS-1:0]     picked_vec;

   // commit-cycle arithmetic from the tail token
   logic                 fin;
   logic [TIME_BITS-1:0] time_inc;
   logic [TIME_BITS-1:0] idle_inc;
   logic [TIME_BITS-1:0] first_run;
   logic [TIME_BITS-1:0] turn_t;
   logic [TIME_BITS-1:0] resp_t;
   srt_pkg::rsp_type     rsp_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_go    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign apply_go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   // service time clipped to the time range; zero work and unknown slots drop
   assign load_work = (32'(req_data.service_time) > 32'(TMAX)) ?
                      TMAX : TIME_BITS'(req_data.service_time);
   assign load_go   = req_go && (req_data.operation == srt_pkg::OP_ARRIVE) &&
                      (load_work != '0) && (32'(req_data.slot) < SLOTS);

   assign tk_found[0] = 1'b0;
   assign tk_rem[0]   = '0;
   assign tk_idx[0]   = '0;
   assign tk_arr[0]   = '0;
   assign tk_wait[0]  = '0;
   assign tk_fr[0]    = '0;
   assign tk_ran[0]   = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      srt_pkg::cell_ctrl_type ctrl;

      assign picked_vec[i] = tk_found[SLOTS] && (tk_idx[SLOTS] == IDX_W'(i));
      assign ctrl.load     = load_go && (32'(req_data.slot) == i);
      assign ctrl.apply    = apply_go;
      assign ctrl.picked   = picked_vec[i];

      srt_cell #(
         .TIME_BITS (TIME_BITS),
         .IDX_W     (IDX_W),
         .IDX       (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .load_work    (load_work),
         .now          (time_ff),
         .tk_found_in  (tk_found[i]),
         .tk_rem_in    (tk_rem[i]),
         .tk_idx_in    (tk_idx[i]),
         .tk_arr_in    (tk_arr[i]),
         .tk_wait_in   (tk_wait[i]),
         .tk_fr_in     (tk_fr[i]),
         .tk_ran_in    (tk_ran[i]),
         .tk_found_out (tk_found[i+1]),
         .tk_rem_out   (tk_rem[i+1]),
         .tk_idx_out   (tk_idx[i+1]),
         .tk_arr_out   (tk_arr[i+1]),
         .tk_wait_out  (tk_wait[i+1]),
         .tk_fr_out    (tk_fr[i+1]),
         .tk_ran_out   (tk_ran[i+1])
      );
   end

   assign time_inc  = (time_ff == TMAX) ? time_ff : time_ff + TIME_BITS'(1);
   assign idle_inc  = (idle_ff == TMAX) ? idle_ff : idle_ff + TIME_BITS'(1);
   // task finishes when its last unit is charged now
   assign fin       = tk_found[SLOTS] && (tk_rem[SLOTS] <= TIME_BITS'(1));
   // first run is this tick if the task never ran before
   assign first_run = tk_ran[SLOTS] ? tk_fr[SLOTS] : time_ff;
   assign turn_t    = time_inc - tk_arr[SLOTS];
   assign resp_t    = first_run - tk_arr[SLOTS];

   always_comb begin
      rsp_in              = '0;
      rsp_in.current_time = 16'(time_ff);
      rsp_in.cpu_idle     = !tk_found[SLOTS];
      rsp_in.idle_ticks   = tk_found[SLOTS] ? 16'(idle_ff) : 16'(idle_inc);
      if (tk_found[SLOTS]) begin
         rsp_in.running_slot = 4'(tk_idx[SLOTS]);
      end
      if (fin) begin
         rsp_in.finished   = 1'b1;
         rsp_in.turnaround = 16'(turn_t);
         rsp_in.waiting    = 16'(tk_wait[SLOTS]);
         rsp_in.response   = 16'(resp_t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         time_ff      <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a commit in the same cycle reloads the result instead
         if (rsp_valid_ff && rsp_ready && !apply_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_go && (req_data.operation == srt_pkg::OP_TICK)) begin
                  state_ff <= ST_SCAN;
                  cnt_ff   <= '0;
               end
            end
            ST_SCAN: begin
               if (cnt_ff == CNT_W'(SLOTS - 1)) begin
                  state_ff <= ST_APPLY;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_APPLY: begin
               if (apply_go) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= rsp_in;
                  time_ff      <= time_inc;
                  if (!tk_found[SLOTS]) begin
                     idle_ff <= idle_inc;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_one_pick: assert property (@(posedge clock) disable iff (reset)
      $onehot0(picked_vec))
      else $error("more than one slot picked");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_APPLY))
      else $error("result raised outside commit");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (time_ff >= $past(time_ff)) && (idle_ff >= $past(idle_ff)))
      else $error("time or idle counter went backward");

   a_time_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(apply_go) |-> $stable(time_ff))
      else $error("time advanced without a tick commit");
`endif

endmodule

`default_nettype wire
